// ===== design/srta_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the digit-to-character function for the radix-to-ASCII unit.
// No dependencies.
package srta_pkg;

	localparam int DIGIT_DEPTH_DEF = 64;
	localparam int MAG_W           = 63;
	localparam int RADIX_W         = 5;
	localparam int MIN_W           = 6;
	localparam int MODE_W          = 2;
	localparam int CHAR_W          = 8;
	localparam int REM_W           = 4;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PLUS  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SPACE = 2'd2;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SIGN,
		ST_ZEROS,
		ST_DIGITS,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] rem;
	} div_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10)
			c = CH_ZERO + CHAR_W'(d);
		else
			c = CH_A + CHAR_W'(d - 4'd10);
		return c;
	endfunction

endpackage

// ===== design/srta_divider.sv =====
`timescale 1ns / 1ps
// Iterative divider of the magnitude by a small base, eight quotient bits a cycle.
// Depends on srta_pkg.
module srta_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [srta_pkg::MAG_W-1:0]   dividend,
	input  logic [srta_pkg::RADIX_W-1:0] radix,
	output logic [srta_pkg::MAG_W-1:0]   quotient,
	output srta_pkg::div_status_t        status
);
	import srta_pkg::*;

	localparam int WORK_W = MAG_W + 1;
	localparam int BITS   = 8;
	localparam int STEPS  = WORK_W / BITS;
	localparam int CNT_W  = $clog2(STEPS);

	logic [WORK_W-1:0]  work_q;
	logic [REM_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;
	logic [WORK_W-1:0]  work_d;
	logic [REM_W-1:0]   rem_d;

	// restoring steps over the top byte of the shift register
	always_comb begin
		logic [RADIX_W-1:0] r;
		logic [BITS-1:0]    qb;
		r  = RADIX_W'(rem_q);
		qb = '0;
		for (int i = 0; i < BITS; i++) begin
			r = {r[RADIX_W-2:0], work_q[WORK_W-1-i]};
			if (r >= radix) begin
				r         = r - radix;
				qb[BITS-1-i] = 1'b1;
			end
		end
		rem_d  = r[REM_W-1:0];
		work_d = {work_q[WORK_W-BITS-1:0], qb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(STEPS - 1));
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			work_q <= {1'b0, dividend};
			rem_q  <= '0;
		end else if (run_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign quotient    = work_q[MAG_W-1:0];
	assign status.done = done_q;
	assign status.rem  = rem_q;

endmodule

// ===== design/srta_digit_ram.sv =====
`timescale 1ns / 1ps
// Digit store: one write port, one registered read port.
// Depends on srta_pkg.
module srta_digit_ram #(
	parameter int DEPTH = srta_pkg::DIGIT_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [srta_pkg::REM_W-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [srta_pkg::REM_W-1:0] rdata
);
	import srta_pkg::*;

	logic [REM_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== design/signed_radix_to_ascii_unit.sv =====
`timescale 1ns / 1ps
// Signed 64-bit to ASCII in base 2..16, most significant character first.
// Division: one digit per pass through the single 8-bit-per-cycle divider.
// Emission: one character per cycle.
// One item at a time; busy stays high until the last character has gone out.
// Results are single-cycle strobes and cannot be stalled. arst_n clears control state.
module signed_radix_to_ascii_unit #(
	parameter int DIGIT_DEPTH = srta_pkg::DIGIT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [63:0]            value,
	input  logic [srta_pkg::RADIX_W-1:0]  radix,
	input  logic [srta_pkg::MIN_W-1:0]    min_digits,
	input  logic [srta_pkg::MODE_W-1:0]   sign_mode,
	output logic                          strobe,
	output logic [srta_pkg::CHAR_W-1:0]   char_out,
	output logic                          last
);
	import srta_pkg::*;

	localparam int AW = $clog2(DIGIT_DEPTH);
	localparam int CW = $clog2(DIGIT_DEPTH + 1);
	localparam int XW = 8;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q;
	logic [MIN_W-1:0]    zcnt_q;
	logic [AW-1:0]       rd_idx_q;
	logic                neg_q;
	logic [MODE_W-1:0]   mode_q;
	logic [MIN_W-1:0]    min_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [CHAR_W-1:0]   char_q;
	logic                chr_valid_q;
	logic                pend_s1;
	logic                plast_s1;

	logic                accept;
	logic                div_load;
	logic [MAG_W-1:0]    div_dividend;
	logic [MAG_W-1:0]    div_quot;
	div_status_t         div_st;
	logic [REM_W-1:0]    rd_data;
	logic [63:0]         abs_v;
	logic [MAG_W-1:0]    mag;
	logic [RADIX_W-1:0]  radix_c;
	logic [CW-1:0]       ncount;
	logic                div_finish;
	logic                has_sign;
	logic [XW-1:0]       zdiff;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	assign abs_v = value[63] ? (~$unsigned(value) + 64'd1) : $unsigned(value);
	assign mag   = abs_v[63] ? MAG_MAX : abs_v[MAG_W-1:0];

	always_comb begin
		if (radix < RADIX_MIN)
			radix_c = RADIX_MIN;
		else if (radix > RADIX_MAX)
			radix_c = RADIX_MAX;
		else
			radix_c = radix;
	end

	assign ncount     = count_q + 1'b1;
	assign div_finish = (state_q == ST_DIVIDE) && div_st.done &&
	                    ((div_quot == '0) || (ncount == CW'(DIGIT_DEPTH)));
	assign has_sign   = neg_q || (mode_q == MODE_PLUS) || (mode_q == MODE_SPACE);
	assign zdiff      = XW'(min_q) - XW'(ncount);

	assign div_load     = accept || ((state_q == ST_DIVIDE) && div_st.done && !div_finish);
	assign div_dividend = accept ? mag : div_quot;

	srta_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (div_dividend),
		.radix    (accept ? radix_c : radix_q),
		.quotient (div_quot),
		.status   (div_st)
	);

	srta_digit_ram #(
		.DEPTH (DIGIT_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    ((state_q == ST_DIVIDE) && div_st.done),
		.waddr (count_q[AW-1:0]),
		.wdata (div_st.rem),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_finish) begin
					if (has_sign)
						state_d = ST_SIGN;
					else if (XW'(min_q) > XW'(ncount))
						state_d = ST_ZEROS;
					else
						state_d = ST_DIGITS;
				end
			end
			ST_SIGN: begin
				state_d = (zcnt_q != '0) ? ST_ZEROS : ST_DIGITS;
			end
			ST_ZEROS: begin
				if (zcnt_q == MIN_W'(1))
					state_d = ST_DIGITS;
			end
			ST_DIGITS: begin
				if (rd_idx_q == '0)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			zcnt_q      <= '0;
			rd_idx_q    <= '0;
			chr_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			plast_s1    <= 1'b0;
		end else begin
			state_q     <= state_d;
			chr_valid_q <= (state_q == ST_SIGN) || (state_q == ST_ZEROS);
			pend_s1     <= (state_q == ST_DIGITS);
			plast_s1    <= (state_q == ST_DIGITS) && (rd_idx_q == '0);
			if (accept)
				count_q <= '0;
			else if ((state_q == ST_DIVIDE) && div_st.done)
				count_q <= ncount;
			if (div_finish) begin
				zcnt_q   <= (XW'(min_q) > XW'(ncount)) ? zdiff[MIN_W-1:0] : '0;
				rd_idx_q <= count_q[AW-1:0];
			end else if (state_q == ST_ZEROS) begin
				zcnt_q <= zcnt_q - 1'b1;
			end else if ((state_q == ST_DIGITS) && (rd_idx_q != '0)) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q   <= value[63];
			mode_q  <= sign_mode;
			min_q   <= min_digits;
			radix_q <= radix_c;
		end
		if (state_q == ST_SIGN) begin
			if (neg_q)
				char_q <= CH_MINUS;
			else if (mode_q == MODE_PLUS)
				char_q <= CH_PLUS;
			else
				char_q <= CH_SPACE;
		end else begin
			char_q <= CH_ZERO;
		end
	end

	assign strobe   = pend_s1 || chr_valid_q;
	assign char_out = pend_s1 ? digit_char(rd_data) : char_q;
	assign last     = pend_s1 && plast_s1;

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		last |=> !busy) else $error("busy after final character");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");

	a_quiet_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !strobe) else $error("character strobe while idle");

	a_no_div_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !div_load) else $error("divider loaded during emission");

endmodule
